[hdl/mipds_pkg.sv]
// Shared types, constants and lane arithmetic for the mip chain downsampler.
package mipds_pkg;

   localparam int MAX_DIM_LOG2_DEF = 12;
   localparam int CSR_DATA_W       = 13;
   localparam int CSR_INDEX_W      = 1;
   localparam int PIXEL_W          = 32;
   localparam int LANES_W          = 40;
   localparam int LEVEL_W          = 4;
   localparam int COORD_W          = 11;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   typedef struct packed {
      logic start;    // latch the accepted pixel, rewind to the first level
      logic look;     // run the horizontal/vertical step of the current level
      logic emit;     // take the averaged pixel, advance to the next level
      logic finish;   // flush the pending result as the last beat of the run
   } cmd_type;

   typedef struct packed {
      logic run_ok;      // current level exists and takes part
      logic vdone;       // last look completed a destination pixel
      logic out_free;    // output register can take a beat this cycle
      logic pend_valid;  // a result is held waiting for its last flag
   } status_type;

   // Spread four bytes into four 10-bit lanes.
   function automatic logic [LANES_W-1:0] widen(input logic [PIXEL_W-1:0] p);
      logic [LANES_W-1:0] r;
      r = '0;
      for (int i = 0; i < 4; i++) begin
         r[10*i +: 10] = {2'b00, p[8*i +: 8]};
      end
      return r;
   endfunction

   // Per lane (sum + 2) / 4, repacked as RGBA8.
   function automatic logic [PIXEL_W-1:0] lanes_to_pixel(input logic [LANES_W-1:0] t);
      logic [PIXEL_W-1:0] r;
      logic [10:0]        v;
      r = '0;
      for (int i = 0; i < 4; i++) begin
         v = {1'b0, t[10*i +: 10]} + 11'd2;
         r[8*i +: 8] = v[9:2];
      end
      return r;
   endfunction

endpackage

[hdl/mipds_req_if.sv]
// Input pixel channel.
interface mipds_req_if import mipds_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel_in;

   modport source (output valid, output pixel_in, input ready);
   modport sink   (input valid, input pixel_in, output ready);
endinterface

[hdl/mipds_rsp_if.sv]
// Result channel carrying produced mip pixels.
interface mipds_rsp_if import mipds_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] mip_level;
   logic [COORD_W-1:0] out_x;
   logic [COORD_W-1:0] out_y;
   logic [PIXEL_W-1:0] pixel_out;
   logic               last_of_run;

   modport source (output valid, output mip_level, output out_x, output out_y,
                   output pixel_out, output last_of_run, input ready);
   modport sink   (input valid, input mip_level, input out_x, input out_y,
                   input pixel_out, input last_of_run, output ready);
endinterface

[hdl/mipds_ram.sv]
// Generic single-port-per-direction RAM with registered read.
module mipds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

[hdl/mipds_ctrl.sv]
// Sequencer stepping one pixel through the level cascade.
module mipds_ctrl import mipds_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_LOOK   = 4'b0010,
      ST_SUM    = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (status.run_ok) begin
               cmd.look = 1'b1;
               state_in = ST_SUM;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SUM: begin
            if (!status.vdone) begin
               state_in = ST_FINISH;
            end else if (!status.pend_valid || status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_LOOK;
            end
         end
         ST_FINISH: begin
            if (!status.pend_valid) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
endmodule

[hdl/mipds_dpath.sv]
// Position counters, pair sums, row store and result registers.
module mipds_dpath import mipds_pkg::*; #(
   parameter int MAX_DIM_LOG2 = MAX_DIM_LOG2_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output status_type             status,
   input  logic [PIXEL_W-1:0]     pixel_in,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   input  logic                   out_ready,
   output logic                   out_valid,
   output logic [LEVEL_W-1:0]     out_level,
   output logic [COORD_W-1:0]     out_x,
   output logic [COORD_W-1:0]     out_y,
   output logic [PIXEL_W-1:0]     out_pixel,
   output logic                   out_last
);
   localparam int DIM_W = MAX_DIM_LOG2;
   localparam int DW    = DIM_W + 1;
   localparam int NL    = MAX_DIM_LOG2;
   localparam int LW    = $clog2(MAX_DIM_LOG2 + 1);
   localparam int IW    = (NL > 1) ? $clog2(NL) : 1;
   localparam logic [DW-1:0] MAX_DIM = DW'(1) << DIM_W;

   logic [CSR_DATA_W-1:0] width_ff, height_ff;
   logic [DIM_W-1:0]      posx_ff [NL];
   logic [DIM_W-1:0]      posy_ff [NL];
   logic [PIXEL_W-1:0]    hold_ff [NL];
   logic [LW-1:0]         lvl_ff, lvl_in;
   logic [PIXEL_W-1:0]    cur_ff, cur_in;
   logic [LANES_W-1:0]    hsum_ff;
   logic [DIM_W-1:0]      dx_ff, dy_ff;
   logic                  vok_ff, hone_ff;
   logic                  pend_valid_ff, pend_valid_in;
   logic [LEVEL_W-1:0]    pend_level_ff;
   logic [COORD_W-1:0]    pend_x_ff, pend_y_ff;
   logic [PIXEL_W-1:0]    pend_pixel_ff;
   logic                  out_valid_ff, out_valid_in;
   logic [LEVEL_W-1:0]    out_level_ff;
   logic [COORD_W-1:0]    out_x_ff, out_y_ff;
   logic [PIXEL_W-1:0]    out_pixel_ff;
   logic                  out_last_ff;

   logic [DW-1:0]      wcl, hcl, lw, lh, lws, lhs, cxn, cyn, base_w;
   logic [IW-1:0]      idx;
   logic [DIM_W-1:0]   cx, cy, dx, ram_addr;
   logic               hdone, row_ok, even_col, ram_we, ram_re, vok;
   logic [LANES_W-1:0] hsum, ram_rdata, total;
   logic [PIXEL_W-1:0] new_pixel;
   logic               csr_hit, push;

   function automatic logic [DW-1:0] clamp_dim(input logic [CSR_DATA_W-1:0] v);
      logic [15:0] v16;
      v16 = 16'(v);
      if (v16 == 16'd0) begin
         return DW'(1);
      end else if (v16 > 16'(MAX_DIM)) begin
         return MAX_DIM;
      end
      return DW'(v);
   endfunction

   assign wcl = clamp_dim(width_ff);
   assign hcl = clamp_dim(height_ff);
   assign lws = wcl >> lvl_ff;
   assign lhs = hcl >> lvl_ff;
   assign lw  = (lws == '0) ? DW'(1) : lws;
   assign lh  = (lhs == '0) ? DW'(1) : lhs;
   assign idx = (lvl_ff < LW'(NL)) ? IW'(lvl_ff) : '0;
   assign cx  = posx_ff[idx];
   assign cy  = posy_ff[idx];
   assign dx  = cx >> 1;

   assign status.run_ok     = (lvl_ff < LW'(NL)) && ((lw > DW'(1)) || (lh > DW'(1)));
   assign status.vdone      = vok_ff;
   assign status.out_free   = !out_valid_ff || out_ready;
   assign status.pend_valid = pend_valid_ff;

   // Horizontal pair: width one doubles the sample, an odd last column drops out.
   always_comb begin
      hsum     = '0;
      hdone    = 1'b0;
      even_col = 1'b0;
      if (lw == DW'(1)) begin
         hsum  = widen(cur_ff) << 1;
         hdone = 1'b1;
      end else if (DW'(cx) < (lw & ~DW'(1))) begin
         if (!cx[0]) begin
            even_col = 1'b1;
         end else begin
            hsum  = widen(hold_ff[idx]) + widen(cur_ff);
            hdone = 1'b1;
         end
      end
   end

   assign row_ok   = (lh != DW'(1)) && (DW'(cy) < (lh & ~DW'(1)));
   assign ram_we   = cmd.look && hdone && row_ok && !cy[0];
   assign ram_re   = cmd.look && hdone && row_ok && cy[0];
   assign vok      = hdone && ((lh == DW'(1)) || (row_ok && cy[0]));
   assign base_w   = MAX_DIM - (MAX_DIM >> lvl_ff);
   assign ram_addr = DIM_W'(base_w) + dx;

   assign cxn = DW'(cx) + DW'(1);
   assign cyn = DW'(cy) + DW'(1);

   mipds_ram #(
      .WIDTH (LANES_W),
      .DEPTH (1 << DIM_W)
   ) u_rows (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_addr),
      .wdata (hsum),
      .re    (ram_re),
      .raddr (ram_addr),
      .rdata (ram_rdata)
   );

   assign total     = hone_ff ? (hsum_ff << 1) : (ram_rdata + hsum_ff);
   assign new_pixel = lanes_to_pixel(total);
   assign push      = cmd.finish || (cmd.emit && pend_valid_ff);
   assign csr_hit   = csr_wr_en;

   always_comb begin
      lvl_in        = lvl_ff;
      cur_in        = cur_ff;
      pend_valid_in = pend_valid_ff;
      if (cmd.start) begin
         lvl_in = '0;
         cur_in = pixel_in;
      end else if (cmd.emit) begin
         lvl_in        = lvl_ff + LW'(1);
         cur_in        = new_pixel;
         pend_valid_in = 1'b1;
      end else if (cmd.finish) begin
         pend_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (push) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= CSR_DATA_W'(1);
         height_ff     <= CSR_DATA_W'(1);
         lvl_ff        <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         vok_ff        <= 1'b0;
         for (int i = 0; i < NL; i++) begin
            posx_ff[i] <= '0;
            posy_ff[i] <= '0;
         end
      end else begin
         lvl_ff        <= lvl_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         if (cmd.look) begin
            vok_ff <= vok;
         end
         if (csr_hit) begin
            if (csr_index == CSR_IMAGE_WIDTH) begin
               width_ff <= csr_wr_data;
            end
            if (csr_index == CSR_IMAGE_HEIGHT) begin
               height_ff <= csr_wr_data;
            end
            for (int i = 0; i < NL; i++) begin
               posx_ff[i] <= '0;
               posy_ff[i] <= '0;
            end
         end else if (cmd.look) begin
            if (cxn >= lw) begin
               posx_ff[idx] <= '0;
               posy_ff[idx] <= (cyn >= lh) ? '0 : DIM_W'(cyn);
            end else begin
               posx_ff[idx] <= DIM_W'(cxn);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (cmd.look) begin
         hsum_ff <= hsum;
         dx_ff   <= dx;
         dy_ff   <= cy >> 1;
         hone_ff <= (lh == DW'(1));
         if (even_col) begin
            hold_ff[idx] <= cur_ff;
         end
      end
      if (cmd.emit) begin
         pend_level_ff <= LEVEL_W'(lvl_ff) + LEVEL_W'(1);
         pend_x_ff     <= COORD_W'(dx_ff);
         pend_y_ff     <= COORD_W'(dy_ff);
         pend_pixel_ff <= new_pixel;
      end
      if (push) begin
         out_level_ff <= pend_level_ff;
         out_x_ff     <= pend_x_ff;
         out_y_ff     <= pend_y_ff;
         out_pixel_ff <= pend_pixel_ff;
         out_last_ff  <= cmd.finish;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_level = out_level_ff;
   assign out_x     = out_x_ff;
   assign out_y     = out_y_ff;
   assign out_pixel = out_pixel_ff;
   assign out_last  = out_last_ff;

   a_push_free: assert property (@(posedge clock) disable iff (reset)
      push |-> (!out_valid_ff || out_ready))
      else $error("result pushed over an untaken beat");
   a_start_clean: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !pend_valid_ff)
      else $error("new pixel started with a result still pending");
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      lvl_ff <= LW'(NL))
      else $error("level counter beyond the chain");
   a_finish_last: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (out_valid_ff && out_last_ff && !pend_valid_ff))
      else $error("flushed result not marked last");
endmodule

[hdl/rgba8_mip_chain_box_downsampler_core.sv]
// Top level of the streaming RGBA8 mip chain box downsampler.
// Sequence: each level visited takes a look state and a sum state; a result is held until the next
//   level resolves, and any pending result is flushed from the finish state as the last beat of the run.
// Acceptance: a new pixel is taken only in idle, once the previous pixel has finished its run; the
//   sequencer visits each level through the registered row store read, and a held output beat stalls it.
// Reset: synchronous; width and height return to 1, all position counters to zero, row store kept.
module rgba8_mip_chain_box_downsampler_core import mipds_pkg::*; #(
   parameter int MAX_DIM_LOG2 = MAX_DIM_LOG2_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   mipds_req_if.sink              req_chan,
   mipds_rsp_if.source            rsp_chan,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);
   cmd_type    cmd;
   status_type status;

   // Sequencer: accept a beat, walk the levels, flush the final result.
   mipds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: hold counters and sums, drive the output register.
   mipds_dpath #(
      .MAX_DIM_LOG2 (MAX_DIM_LOG2)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .pixel_in    (req_chan.pixel_in),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .out_ready   (rsp_chan.ready),
      .out_valid   (rsp_chan.valid),
      .out_level   (rsp_chan.mip_level),
      .out_x       (rsp_chan.out_x),
      .out_y       (rsp_chan.out_y),
      .out_pixel   (rsp_chan.pixel_out),
      .out_last    (rsp_chan.last_of_run)
   );
endmodule
